// ----- rtl/obmb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package obmb_pkg;

   localparam logic [1:0] CMD_APPEND = 2'd0;
   localparam logic [1:0] CMD_MOVE   = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;
   localparam logic [1:0] CMD_CLEAR  = 2'd3;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_INVALID = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;
   localparam logic [1:0] STATUS_RANGE   = 2'd3;

   typedef struct packed {
      logic        [1:0]  cmd;
      logic signed [31:0] value;
      logic        [7:0]  index;
      logic        [8:0]  range_first;
      logic        [8:0]  range_last;
      logic        [8:0]  dest;
   } req_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic        [1:0]  status;
      logic        [8:0]  length;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/overwriting_block_move_buffer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Payload
// req_      in         req_valid / req_stall   obmb_pkg::req_type
// rsp_      out        rsp_valid / rsp_stall   obmb_pkg::rsp_type
//
// Append, read, clear and a rejected or null move go from the transfer in straight
// to the done state, which loads the output register.
// A move walks total positions, where total is the larger of the length and the
// destination end, gathering the k words of the new length into the scratch
// memory, then copies the k words back, each one word a cycle.
// Reset clears the length and the control state; the memories are not cleared.
// A new command is taken while the previous result still waits in the output
// register; a stalled result holds the block in its final cycle.

module overwriting_block_move_buffer #(
   parameter int DEPTH     = 256,
   parameter int WORD_BITS = 32
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  obmb_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output obmb_pkg::rsp_type  rsp_data
);

   import obmb_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = CW + 1;
   localparam int PW = (IW > 9) ? IW : 9;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_WALK   = 3'd1;
   localparam logic [2:0] S_WFLUSH = 3'd2;
   localparam logic [2:0] S_COPY   = 3'd3;
   localparam logic [2:0] S_CFLUSH = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [WORD_BITS-1:0] word_mem [DEPTH];
   logic [WORD_BITS-1:0] scratch_mem [DEPTH];

   logic [2:0]           state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        k_ff, k_in;
   logic [PW-1:0]        i_ff, i_in;
   logic [PW-1:0]        first_ff, first_in;
   logic [PW-1:0]        last_ff, last_in;
   logic [PW-1:0]        dest_ff, dest_in;
   logic [PW-1:0]        olast_ff, olast_in;
   logic [PW-1:0]        total_ff, total_in;
   logic [1:0]           status_ff, status_in;
   logic                 rdres_ff, rdres_in;
   logic                 wp_valid_ff, wp_valid_in;
   logic [AW-1:0]        wp_addr_ff, wp_addr_in;
   logic                 cp_valid_ff, cp_valid_in;
   logic [AW-1:0]        cp_addr_ff, cp_addr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;
   logic [WORD_BITS-1:0] wrd_ff;
   logic [WORD_BITS-1:0] srd_ff;

   logic                 req_accept;
   logic                 wmem_re, wmem_we, smem_re;
   logic [AW-1:0]        wmem_raddr, wmem_waddr;
   logic [WORD_BITS-1:0] wmem_wdata;
   logic [WORD_BITS-1:0] append_word;
   logic [31:0]          rd_word;

   logic [PW-1:0]        n_ext, rf_ext, rl_ext, rd_ext, olast_calc;
   logic                 in_dest, in_src, keep;
   logic [PW-1:0]        src;

   generate
      if (WORD_BITS >= 32) begin : g_wide
         assign rd_word     = wrd_ff[31:0];
         assign append_word = WORD_BITS'(req_data.value);
      end else begin : g_narrow
         assign rd_word     = 32'(wrd_ff);
         assign append_word = req_data.value[WORD_BITS-1:0];
      end
   endgenerate

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign n_ext      = PW'(count_ff);
   assign rf_ext     = PW'(req_data.range_first);
   assign rl_ext     = PW'(req_data.range_last);
   assign rd_ext     = PW'(req_data.dest);
   assign olast_calc = rd_ext + (rl_ext - rf_ext);

   // Classification of the current walk position against both ranges.
   assign in_dest = (i_ff >= dest_ff) && (i_ff < olast_ff);
   assign in_src  = (i_ff >= first_ff) && (i_ff < last_ff);
   assign keep    = !(in_src && !in_dest);
   assign src     = in_dest ? (first_ff + (i_ff - dest_ff)) : i_ff;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      k_in        = k_ff;
      i_in        = i_ff;
      first_in    = first_ff;
      last_in     = last_ff;
      dest_in     = dest_ff;
      olast_in    = olast_ff;
      total_in    = total_ff;
      status_in   = status_ff;
      rdres_in    = rdres_ff;
      wp_valid_in = 1'b0;
      wp_addr_in  = wp_addr_ff;
      cp_valid_in = 1'b0;
      cp_addr_in  = cp_addr_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wmem_re     = 1'b0;
      wmem_raddr  = '0;
      smem_re     = 1'b0;
      wmem_we     = cp_valid_ff;
      wmem_waddr  = cp_addr_ff;
      wmem_wdata  = srd_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               rdres_in  = 1'b0;
               status_in = STATUS_OK;
               state_in  = S_DONE;
               case (req_data.cmd)
                  CMD_APPEND: begin
                     if (count_ff < CW'(DEPTH)) begin
                        wmem_we    = 1'b1;
                        wmem_waddr = AW'(count_ff);
                        wmem_wdata = append_word;
                        count_in   = count_ff + 1'b1;
                     end else begin
                        status_in = STATUS_FULL;
                     end
                  end
                  CMD_MOVE: begin
                     if ((rl_ext <= rf_ext) || (rl_ext > n_ext) || (rd_ext > n_ext)) begin
                        status_in = STATUS_INVALID;
                     end else if (rd_ext != rf_ext) begin
                        first_in = rf_ext;
                        last_in  = rl_ext;
                        dest_in  = rd_ext;
                        olast_in = olast_calc;
                        total_in = (olast_calc > n_ext) ? olast_calc : n_ext;
                        i_in     = '0;
                        k_in     = '0;
                        state_in = S_WALK;
                     end
                  end
                  CMD_READ: begin
                     if (PW'(req_data.index) < n_ext) begin
                        wmem_re    = 1'b1;
                        wmem_raddr = AW'(req_data.index);
                        rdres_in   = 1'b1;
                     end else begin
                        status_in = STATUS_RANGE;
                     end
                  end
                  default: begin
                     count_in = '0;
                  end
               endcase
            end
         end
         S_WALK: begin
            // Gather the surviving words in their new order into the scratch memory.
            if (keep) begin
               wmem_re    = 1'b1;
               wmem_raddr = src[AW-1:0];
               if (k_ff < CW'(DEPTH)) begin
                  wp_valid_in = 1'b1;
                  wp_addr_in  = AW'(k_ff);
                  k_in        = k_ff + 1'b1;
               end
            end
            i_in = i_ff + 1'b1;
            if (i_ff == total_ff - 1'b1) begin
               state_in = S_WFLUSH;
            end
         end
         S_WFLUSH: begin
            i_in     = '0;
            state_in = S_COPY;
         end
         S_COPY: begin
            smem_re     = 1'b1;
            cp_valid_in = 1'b1;
            cp_addr_in  = i_ff[AW-1:0];
            i_in        = i_ff + 1'b1;
            if (i_ff + 1'b1 == PW'(k_ff)) begin
               state_in = S_CFLUSH;
            end
         end
         S_CFLUSH: begin
            count_in = k_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.read_value = rdres_ff ? rd_word : 32'd0;
               rsp_data_in.status     = status_ff;
               rsp_data_in.length     = 9'(count_ff);
               state_in               = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         wp_valid_ff  <= 1'b0;
         cp_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         wp_valid_ff  <= wp_valid_in;
         cp_valid_ff  <= cp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      i_ff        <= i_in;
      first_ff    <= first_in;
      last_ff     <= last_in;
      dest_ff     <= dest_in;
      olast_ff    <= olast_in;
      total_ff    <= total_in;
      status_ff   <= status_in;
      rdres_ff    <= rdres_in;
      wp_addr_ff  <= wp_addr_in;
      cp_addr_ff  <= cp_addr_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wmem_we) begin
         word_mem[wmem_waddr] <= wmem_wdata;
      end
      if (wmem_re) begin
         wrd_ff <= word_mem[wmem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (wp_valid_ff) begin
         scratch_mem[wp_addr_ff] <= wrd_ff;
      end
      if (smem_re) begin
         srd_ff <= scratch_mem[i_ff[AW-1:0]];
      end
   end

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

import obmb_pkg::*;

class buffer_scoreboard;
   logic [31:0] words [256];
   logic [8:0]  word_total;
   rsp_type     expected_q [$];
   int          mismatches;
   int          requests_seen;

   function new();
      word_total    = '0;
      mismatches    = 0;
      requests_seen = 0;
   endfunction

   task report(string msg);
      $display("MISMATCH: %s", msg);
      mismatches++;
   endtask

   // Works out the result of one accepted command and updates the shadow buffer.
   function void note_request(req_type it);
      rsp_type     o;
      int unsigned n, first, last, dst, span, dst_end, total, k, src, i;
      logic [31:0] moved [256];
      bit          in_dst, in_src;
      o = '0;
      requests_seen++;
      n     = 32'(word_total);
      first = 32'(it.range_first);
      last  = 32'(it.range_last);
      dst   = 32'(it.dest);
      case (it.cmd)
         CMD_APPEND: begin
            if (n >= 256) begin
               o.status = STATUS_FULL;
            end else begin
               words[n]   = it.value;
               word_total = 9'(n + 1);
            end
         end
         CMD_MOVE: begin
            if (last <= first || last > n || dst > n) begin
               o.status = STATUS_INVALID;
            end else if (dst != first) begin
               span    = last - first;
               dst_end = dst + span;
               total   = (dst_end > n) ? dst_end : n;
               k       = 0;
               for (i = 0; i < total; i++) begin
                  in_dst = (i >= dst) && (i < dst_end);
                  in_src = (i >= first) && (i < last);
                  // Source positions left uncovered by the destination are dropped.
                  if (!(in_src && !in_dst)) begin
                     src = in_dst ? first + (i - dst) : i;
                     if (k < 256) moved[k] = words[src];
                     k++;
                  end
               end
               if (k > 256) k = 256;
               for (i = 0; i < k; i++) words[i] = moved[i];
               word_total = 9'(k);
            end
         end
         CMD_READ: begin
            if (32'(it.index) < n) o.read_value = words[it.index];
            else o.status = STATUS_RANGE;
         end
         default: word_total = '0;
      endcase
      o.length = word_total;
      expected_q = {expected_q, o};
   endfunction

   task check_response(rsp_type got);
      rsp_type want;
      if (expected_q.size() == 0) begin
         report($sformatf("result %h arrived with nothing outstanding", got));
         return;
      end
      want = expected_q.pop_front();
      if (got.read_value !== want.read_value)
         report($sformatf("read_value %h, predicted %h", got.read_value, want.read_value));
      if (got.status !== want.status)
         report($sformatf("status %0d, predicted %0d", got.status, want.status));
      if (got.length !== want.length)
         report($sformatf("length %0d, predicted %0d", got.length, want.length));
   endtask
endclass

module tb_top;

   localparam int  RANDOM_ITEMS = 1950;
   localparam int  HOLD_CYCLES  = 400;
   localparam longint CYCLE_LIMIT = 20_000_000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   buffer_scoreboard sb = new();

   bit     hold_active = 1'b0;
   bit     held_off    = 1'b0;
   int     burst_left  = 0;
   longint cycles      = 0;

   overwriting_block_move_buffer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_data);
   end

   function automatic req_type make_req(logic [1:0] c, logic [31:0] v, int idx,
                                        int f, int l, int d);
      req_type it;
      it.cmd         = c;
      it.value       = v;
      it.index       = 8'(idx);
      it.range_first = 9'(f);
      it.range_last  = 9'(l);
      it.dest        = 9'(d);
      return it;
   endfunction

   // Mostly back-to-back or short gaps, now and then a long one or a burst with none.
   function automatic int pick_gap();
      int r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 10) begin
         burst_left = $urandom_range(20, 100);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic req_type random_item();
      req_type it;
      int      r, n, f, l;
      n = 32'(sb.word_total);
      it = make_req(CMD_APPEND, $urandom, $urandom_range(0, 255), $urandom_range(0, 511),
                    $urandom_range(0, 511), $urandom_range(0, 511));
      r = $urandom_range(0, 99);
      if (r < 40) begin
         it.cmd = CMD_APPEND;
      end else if (r < 65) begin
         it.cmd = CMD_MOVE;
         if (n > 0 && $urandom_range(0, 9) < 8) begin
            f = $urandom_range(0, n - 1);
            it.range_first = 9'(f);
            it.range_last  = 9'($urandom_range(f + 1, n));
            it.dest        = ($urandom_range(0, 5) == 0) ? 9'(f) : 9'($urandom_range(0, n));
         end else begin
            case ($urandom_range(0, 3))
               0: begin
                  f = $urandom_range(0, n);
                  it.range_first = 9'(f);
                  it.range_last  = 9'($urandom_range(0, f));
               end
               1: begin
                  l = $urandom_range(n + 1, 511);
                  it.range_last  = 9'(l);
                  it.range_first = 9'($urandom_range(0, l - 1));
               end
               2: it.dest = 9'($urandom_range(n + 1, 511));
               default: ;
            endcase
         end
      end else if (r < 92) begin
         it.cmd = CMD_READ;
         if (n > 0 && $urandom_range(0, 9) < 8) it.index = 8'($urandom_range(0, n - 1));
      end else if (r < 95) begin
         it.cmd = CMD_CLEAR;
      end else begin
         it.cmd = 2'($urandom_range(0, 3));
      end
      return it;
   endfunction

   task automatic send(req_type it);
      int gap;
      gap = hold_active ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  = it;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note_request(it);
      @(negedge clock);
   endtask

   task automatic fill_and_shuffle();
      int f;
      while (sb.word_total < 256) send(make_req(CMD_APPEND, $urandom, 0, 0, 0, 0));
      repeat (3) send(make_req(CMD_APPEND, $urandom, 0, 0, 0, 0));
      send(make_req(CMD_READ, 0, 255, 0, 0, 0));
      send(make_req(CMD_READ, 0, 0, 0, 0, 0));
      // Destination at the very end: the copy runs past the old length and the uncovered source words are dropped.
      send(make_req(CMD_MOVE, 0, 0, 0, 10, 256));
      send(make_req(CMD_MOVE, 0, 0, 246, 256, 0));
      send(make_req(CMD_MOVE, 0, 0, 100, 200, 150));
      repeat (3) begin
         f = $urandom_range(0, sb.word_total - 1);
         send(make_req(CMD_MOVE, 0, 0, f, $urandom_range(f + 1, sb.word_total),
                       $urandom_range(0, sb.word_total)));
      end
      repeat (3) send(make_req(CMD_READ, 0, $urandom_range(0, 255), 0, 0, 0));
   endtask

   // Receiver: random stalls, stretches without any, and one long hold-off.
   initial begin
      int r, run;
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!held_off && sb.requests_seen >= 600) begin
            held_off    = 1'b1;
            hold_active = 1'b1;
            rsp_stall   = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_active = 1'b0;
         end
         r = $urandom_range(0, 99);
         if (r < 30) begin
            rsp_stall = 1'b0;
            repeat ($urandom_range(20, 150)) @(negedge clock);
         end else begin
            rsp_stall = 1'b1;
            run = (r < 94) ? $urandom_range(1, 3) : $urandom_range(10, 60);
            repeat (run) @(negedge clock);
            rsp_stall = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
   end

   initial begin
      int target, episode;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Empty buffer: reading and moving are both rejected.
      send(make_req(CMD_READ, 0, 0, 0, 0, 0));
      send(make_req(CMD_MOVE, 0, 0, 0, 1, 0));
      send(make_req(CMD_APPEND, 32'h8000_0000, 0, 0, 0, 0));
      send(make_req(CMD_APPEND, 32'h7FFF_FFFF, 0, 0, 0, 0));
      send(make_req(CMD_APPEND, 32'h0000_0000, 0, 0, 0, 0));
      send(make_req(CMD_APPEND, 32'hFFFF_FFFF, 0, 0, 0, 0));
      send(make_req(CMD_APPEND, 32'h5555_5555, 0, 0, 0, 0));
      send(make_req(CMD_APPEND, 32'hAAAA_AAAA, 0, 0, 0, 0));
      send(make_req(CMD_READ, 0, 0, 0, 0, 0));
      send(make_req(CMD_READ, 0, 5, 0, 0, 0));
      send(make_req(CMD_READ, 0, 6, 0, 0, 0));
      send(make_req(CMD_READ, 0, 255, 0, 0, 0));
      send(make_req(CMD_MOVE, 0, 0, 2, 2, 0));
      send(make_req(CMD_MOVE, 0, 0, 1, 3, 7));
      send(make_req(CMD_MOVE, 0, 0, 1, 3, 1));
      send(make_req(CMD_MOVE, 0, 0, 0, 2, 4));
      // Copy extends past the end, then the uncovered source words are closed up.
      send(make_req(CMD_MOVE, 0, 0, 1, 4, 3));
      send(make_req(CMD_MOVE, 0, 0, 2, 4, 0));
      for (int i = 0; i < 4; i++) send(make_req(CMD_READ, 0, i, 0, 0, 0));
      send(make_req(CMD_CLEAR, 0, 0, 0, 0, 0));
      send(make_req(CMD_READ, 0, 0, 0, 0, 0));
      send(make_req(CMD_APPEND, 32'h1234_5678, 0, 0, 0, 0));

      target  = sb.requests_seen + RANDOM_ITEMS;
      episode = 0;
      while (sb.requests_seen < target) begin
         if (episode % 20 == 0) begin
            fill_and_shuffle();
         end else begin
            if ($urandom_range(0, 9) < 7) send(make_req(CMD_CLEAR, $urandom, 0, 0, 0, 0));
            repeat ($urandom_range(10, 60)) send(random_item());
         end
         episode++;
      end

      req_valid = 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (sb.mismatches == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
